/* rtl/lr_pkg.sv */
`timescale 1ns / 1ps

package lr_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic x_is_major;
        logic minor_down;
    } line_flags_t;

endpackage

/* rtl/lr_setup.sv */
`timescale 1ns / 1ps

module lr_setup import lr_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]        start_x,
    input  logic [COORD_BITS-1:0]        start_y,
    input  logic [COORD_BITS-1:0]        end_x,
    input  logic [COORD_BITS-1:0]        end_y,
    output logic [COORD_BITS-1:0]        cur_x,
    output logic [COORD_BITS-1:0]        cur_y,
    output logic [COORD_BITS-1:0]        major_end,
    output logic signed [COORD_BITS+2:0] decision,
    output logic [COORD_BITS+1:0]        incr_straight,
    output logic signed [COORD_BITS+2:0] incr_diagonal,
    output line_flags_t                  flags,
    output logic                         active
);

    logic                         swap;
    logic [COORD_BITS-1:0]        ax;
    logic [COORD_BITS-1:0]        ay;
    logic [COORD_BITS-1:0]        bx;
    logic [COORD_BITS-1:0]        by;
    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        dy;
    logic                         y_up;
    logic                         x_major;
    logic [COORD_BITS-1:0]        span_major;
    logic [COORD_BITS-1:0]        span_minor;
    logic signed [COORD_BITS+1:0] span_diff;

    // order endpoints so x does not decrease
    assign swap = end_x < start_x;
    assign ax   = swap ? end_x   : start_x;
    assign ay   = swap ? end_y   : start_y;
    assign bx   = swap ? start_x : end_x;
    assign by   = swap ? start_y : end_y;

    assign dx      = bx - ax;
    assign y_up    = by >= ay;
    assign dy      = y_up ? (by - ay) : (ay - by);
    assign x_major = dx > dy;

    assign span_major = x_major ? dx : dy;
    assign span_minor = x_major ? dy : dx;

    always_comb
    begin
        flags.x_is_major = x_major;
        if (x_major)
        begin
            cur_x            = ax;
            cur_y            = ay;
            major_end        = bx;
            flags.minor_down = !y_up;
        end
        else if (y_up)
        begin
            cur_x            = ax;
            cur_y            = ay;
            major_end        = by;
            flags.minor_down = 1'b0;
        end
        else
        begin
            // y-major falling line: start from the lower point, x walks back
            cur_x            = bx;
            cur_y            = by;
            major_end        = ay;
            flags.minor_down = (dx != '0);
        end
    end

    assign decision      = $signed({2'b00, span_minor, 1'b0}) - $signed({3'b000, span_major});
    assign incr_straight = {1'b0, span_minor, 1'b0};
    assign span_diff     = $signed({2'b00, span_minor}) - $signed({2'b00, span_major});
    assign incr_diagonal = {span_diff, 1'b0};
    assign active        = (span_major != '0);

endmodule

/* rtl/lr_step.sv */
`timescale 1ns / 1ps

module lr_step import lr_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]        cur_x,
    input  logic [COORD_BITS-1:0]        cur_y,
    input  logic signed [COORD_BITS+2:0] decision,
    input  logic [COORD_BITS+1:0]        incr_straight,
    input  logic signed [COORD_BITS+2:0] incr_diagonal,
    input  logic [COORD_BITS-1:0]        major_end,
    input  line_flags_t                  flags,
    output logic [COORD_BITS-1:0]        next_x,
    output logic [COORD_BITS-1:0]        next_y,
    output logic signed [COORD_BITS+2:0] next_decision,
    output logic                         done
);

    logic                  diag;
    logic [COORD_BITS-1:0] minor_cur;
    logic [COORD_BITS-1:0] minor_next;
    logic [COORD_BITS-1:0] major_next;

    assign diag = !decision[COORD_BITS+2] && (decision != '0);

    assign next_decision = diag ? (decision + incr_diagonal)
                                : (decision + $signed({1'b0, incr_straight}));

    assign minor_cur  = flags.x_is_major ? cur_y : cur_x;
    assign major_next = (flags.x_is_major ? cur_x : cur_y) + COORD_BITS'(1);

    always_comb
    begin
        if (!diag)
            minor_next = minor_cur;
        else if (flags.minor_down)
            minor_next = minor_cur - COORD_BITS'(1);
        else
            minor_next = minor_cur + COORD_BITS'(1);
    end

    assign next_x = flags.x_is_major ? major_next : minor_next;
    assign next_y = flags.x_is_major ? minor_next : major_next;
    assign done   = (major_next == major_end);

endmodule

/* rtl/line_rasterizer.sv */
`timescale 1ns / 1ps

// Bresenham line rasterizer, one request in, one pixel result out.
// Input register, then result register, from request acceptance to result valid.
// One request per cycle unless stalled; the line state updates in the same cycle
// a request leaves the input register, so steps follow back to back.
// Reset clears the line state (no active line) and empties both registers.
module line_rasterizer import lr_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  valid_res,
    output logic                  last
);

    // input register
    logic                  in_full_reg;
    logic                  in_full_next;
    logic                  op_reg;
    logic [COORD_BITS-1:0] sx_reg;
    logic [COORD_BITS-1:0] sy_reg;
    logic [COORD_BITS-1:0] ex_reg;
    logic [COORD_BITS-1:0] ey_reg;

    // line state
    logic                        active_reg;
    logic                        active_next;
    logic [COORD_BITS-1:0]       cur_x_reg;
    logic [COORD_BITS-1:0]       cur_x_next;
    logic [COORD_BITS-1:0]       cur_y_reg;
    logic [COORD_BITS-1:0]       cur_y_next;
    logic signed [COORD_BITS+2:0] decision_reg;
    logic signed [COORD_BITS+2:0] decision_next;
    logic [COORD_BITS+1:0]       incr_straight_reg;
    logic [COORD_BITS+1:0]       incr_straight_next;
    logic signed [COORD_BITS+2:0] incr_diagonal_reg;
    logic signed [COORD_BITS+2:0] incr_diagonal_next;
    logic [COORD_BITS-1:0]       major_end_reg;
    logic [COORD_BITS-1:0]       major_end_next;
    line_flags_t                 flags_reg;
    line_flags_t                 flags_next;

    // result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic [COORD_BITS-1:0] pixel_y_next;
    logic                  valid_res_reg;
    logic                  valid_res_next;
    logic                  last_reg;
    logic                  last_next;

    logic in_accept;
    logic advance;

    // setup and step results
    logic [COORD_BITS-1:0]        ld_x;
    logic [COORD_BITS-1:0]        ld_y;
    logic [COORD_BITS-1:0]        ld_major_end;
    logic signed [COORD_BITS+2:0] ld_decision;
    logic [COORD_BITS+1:0]        ld_incr_straight;
    logic signed [COORD_BITS+2:0] ld_incr_diagonal;
    line_flags_t                  ld_flags;
    logic                         ld_active;
    logic [COORD_BITS-1:0]        st_x;
    logic [COORD_BITS-1:0]        st_y;
    logic signed [COORD_BITS+2:0] st_decision;
    logic                         st_done;

    assign advance   = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;
    assign in_accept = in_valid && in_ready;

    lr_setup #(
        .COORD_BITS(COORD_BITS)
    ) u_setup (
        .start_x       (sx_reg),
        .start_y       (sy_reg),
        .end_x         (ex_reg),
        .end_y         (ey_reg),
        .cur_x         (ld_x),
        .cur_y         (ld_y),
        .major_end     (ld_major_end),
        .decision      (ld_decision),
        .incr_straight (ld_incr_straight),
        .incr_diagonal (ld_incr_diagonal),
        .flags         (ld_flags),
        .active        (ld_active)
    );

    lr_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .cur_x         (cur_x_reg),
        .cur_y         (cur_y_reg),
        .decision      (decision_reg),
        .incr_straight (incr_straight_reg),
        .incr_diagonal (incr_diagonal_reg),
        .major_end     (major_end_reg),
        .flags         (flags_reg),
        .next_x        (st_x),
        .next_y        (st_y),
        .next_decision (st_decision),
        .done          (st_done)
    );

    always_comb
    begin
        in_full_next = in_accept ? 1'b1 : (advance ? 1'b0 : in_full_reg);

        active_next        = active_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        decision_next      = decision_reg;
        incr_straight_next = incr_straight_reg;
        incr_diagonal_next = incr_diagonal_reg;
        major_end_next     = major_end_reg;
        flags_next         = flags_reg;

        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        valid_res_next = valid_res_reg;
        last_next      = last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            if (op_reg == OP_LOAD)
            begin
                active_next        = ld_active;
                cur_x_next         = ld_x;
                cur_y_next         = ld_y;
                decision_next      = ld_decision;
                incr_straight_next = ld_incr_straight;
                incr_diagonal_next = ld_incr_diagonal;
                major_end_next     = ld_major_end;
                flags_next         = ld_flags;
                pixel_x_next       = ld_x;
                pixel_y_next       = ld_y;
                valid_res_next     = 1'b1;
                last_next          = !ld_active;
            end
            else if (active_reg)
            begin
                active_next    = !st_done;
                cur_x_next     = st_x;
                cur_y_next     = st_y;
                decision_next  = st_decision;
                pixel_x_next   = st_x;
                pixel_y_next   = st_y;
                valid_res_next = 1'b1;
                last_next      = st_done;
            end
            else
            begin
                // step with no line: empty result, state untouched
                pixel_x_next   = '0;
                pixel_y_next   = '0;
                valid_res_next = 1'b0;
                last_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            active_reg        <= 1'b0;
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            decision_reg      <= '0;
            incr_straight_reg <= '0;
            incr_diagonal_reg <= '0;
            major_end_reg     <= '0;
            flags_reg         <= '0;
        end
        else
        begin
            in_full_reg       <= in_full_next;
            out_valid_reg     <= out_valid_next;
            active_reg        <= active_next;
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            decision_reg      <= decision_next;
            incr_straight_reg <= incr_straight_next;
            incr_diagonal_reg <= incr_diagonal_next;
            major_end_reg     <= major_end_next;
            flags_reg         <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= opcode;
            sx_reg <= start_x;
            sy_reg <= start_y;
            ex_reg <= end_x;
            ey_reg <= end_y;
        end
        pixel_x_reg   <= pixel_x_next;
        pixel_y_reg   <= pixel_y_next;
        valid_res_reg <= valid_res_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign valid_res = valid_res_reg;
    assign last      = last_reg;

    // an active line never sits on its end coordinate
    a_active_not_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((flags_reg.x_is_major ? cur_x_reg : cur_y_reg) != major_end_reg))
        else $error("active line already at its end coordinate");

    // last flag marks exactly the request that closed the line
    a_last_closes_line: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && (last_reg == (valid_res_reg && !active_reg))))
        else $error("last flag does not match line completion");

    // a step with no line leaves the line state alone
    a_idle_step_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg == OP_STEP && !active_reg)
            |=> ($stable(cur_x_reg) && $stable(cur_y_reg) && $stable(decision_reg)
                 && !active_reg))
        else $error("idle step changed line state");

    // an empty result carries no pixel
    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !valid_res_reg) |-> (!last_reg && pixel_x_reg == '0
                                               && pixel_y_reg == '0))
        else $error("empty result carries pixel data");

endmodule
